FILE: design/register_alu_branch_execute_top_assert.svh
// ----------------------------------------------------------------------------
// Register ALU branch execute assertion macros
// Shared property templates for the concurrent checks of the execute block.
// ----------------------------------------------------------------------------
`ifndef REGISTER_ALU_BRANCH_EXECUTE_TOP_ASSERT_SVH
`define REGISTER_ALU_BRANCH_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RABE_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RABE_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rabe_pkg.sv
// ----------------------------------------------------------------------------
// Register ALU branch execute package
// Word types, opcodes and shared widths of the execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package rabe_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 5;
  localparam int REG_IDX_W = 4;
  localparam int TGT_W     = 10;
  localparam int NPC_W     = 10;
  localparam int DIV_CNT_W = $clog2(DATA_W);
  localparam int RECIP_SH  = 20;
  localparam int TPROD_W   = 27;
  localparam int TQ_W      = 6;
  localparam int TREM_W    = 17;

  localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
  localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
  localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
  localparam logic [OP_W-1:0] OP_AND  = 5'd4;
  localparam logic [OP_W-1:0] OP_OR   = 5'd5;
  localparam logic [OP_W-1:0] OP_XOR  = 5'd6;
  localparam logic [OP_W-1:0] OP_SHR  = 5'd7;
  localparam logic [OP_W-1:0] OP_SHL  = 5'd8;
  localparam logic [OP_W-1:0] OP_MOV  = 5'd9;
  localparam logic [OP_W-1:0] OP_CMP  = 5'd10;
  localparam logic [OP_W-1:0] OP_INC  = 5'd11;
  localparam logic [OP_W-1:0] OP_DEC  = 5'd12;
  localparam logic [OP_W-1:0] OP_READ = 5'd13;
  localparam logic [OP_W-1:0] OP_JMP  = 5'd14;
  localparam logic [OP_W-1:0] OP_JZ   = 5'd15;
  localparam logic [OP_W-1:0] OP_JL   = 5'd16;
  localparam logic [OP_W-1:0] OP_JLE  = 5'd17;
  localparam logic [OP_W-1:0] OP_JE   = 5'd18;
  localparam logic [OP_W-1:0] OP_JG   = 5'd19;
  localparam logic [OP_W-1:0] OP_JGE  = 5'd20;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic [REG_IDX_W-1:0]   dest_reg;
    logic                   src_is_imm;
    logic [REG_IDX_W-1:0]   src_reg;
    logic signed [DATA_W-1:0] imm;
    logic [TGT_W-1:0]       target;
  } in_t;

  typedef struct packed {
    logic [NPC_W-1:0]       next_pc;
    logic signed [DATA_W-1:0] value;
    logic                   error;
    logic                   flag_zero;
    logic                   flag_equal;
    logic                   flag_low;
    logic                   flag_great;
  } out_t;

  typedef struct packed {
    logic zero;
    logic equal;
    logic low;
    logic great;
  } flags_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              wr;
    logic              jump;
    logic              is_div;
    logic              div_zero;
    flags_t            flags;
  } alu_res_t;

endpackage

`default_nettype wire

FILE: design/rabe_regfile.sv
// ----------------------------------------------------------------------------
// Register file
// Synchronous memory with two registered read ports, one write port and a
// valid bit per entry so that entries not yet written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rabe_regfile #(
  parameter int NUM_REGS = 10,
  parameter int AW       = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rd_en,
  input  wire logic [AW-1:0]                 rd_addr_a,
  input  wire logic [AW-1:0]                 rd_addr_b,
  output logic      [rabe_pkg::DATA_W-1:0]   rd_data_a,
  output logic      [rabe_pkg::DATA_W-1:0]   rd_data_b,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [rabe_pkg::DATA_W-1:0]   wr_data
);
  import rabe_pkg::*;

  logic [DATA_W-1:0]   mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [DATA_W-1:0]   q_a_r;
  logic [DATA_W-1:0]   q_b_r;
  logic                va_r;
  logic                vb_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_a_r <= mem[rd_addr_a];
      q_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        va_r <= vld_r[rd_addr_a];
        vb_r <= vld_r[rd_addr_b];
      end
    end
  end

  assign rd_data_a = va_r ? q_a_r : '0;
  assign rd_data_b = vb_r ? q_b_r : '0;

endmodule

`default_nettype wire

FILE: design/rabe_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Signed division truncating toward zero, one quotient bit per cycle on the
// operand magnitudes, with the sign applied at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module rabe_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rabe_pkg::DATA_W-1:0] dividend,
  input  wire logic [rabe_pkg::DATA_W-1:0] divisor,
  output logic                             done,
  output logic      [rabe_pkg::DATA_W-1:0] quotient
);
  import rabe_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic                 neg_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DATA_W-1:0]    den_r;
  logic [DATA_W-1:0]    mag_a;
  logic [DATA_W-1:0]    mag_b;
  logic [DATA_W:0]      shf;
  logic [DATA_W:0]      dif;
  logic                 fits;

  assign mag_a = dividend[DATA_W-1] ? ('0 - dividend) : dividend;
  assign mag_b = divisor[DATA_W-1] ? ('0 - divisor) : divisor;
  assign shf   = {rem_r, quo_r[DATA_W-1]};
  assign dif   = shf - {1'b0, den_r};
  assign fits  = (shf >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      den_r <= mag_b;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? dif[DATA_W-1:0] : shf[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? ('0 - quo_r) : quo_r;

endmodule

`default_nettype wire

FILE: design/rabe_alu.sv
// ----------------------------------------------------------------------------
// Execute ALU
// Decodes one instruction and gives its result (not a quotient), write enable,
// new compare flags and branch decision from the operands and current flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rabe_alu (
  input  wire logic [rabe_pkg::OP_W-1:0]   op,
  input  wire logic [rabe_pkg::DATA_W-1:0] op_a,
  input  wire logic [rabe_pkg::DATA_W-1:0] op_b,
  input  wire rabe_pkg::flags_t            flags_in,
  output rabe_pkg::alu_res_t               res
);
  import rabe_pkg::*;

  logic [DATA_W-1:0] mul_lo;
  logic [4:0]        shamt;

  assign mul_lo = op_a * op_b;
  assign shamt  = op_b[4:0];

  always_comb begin
    res          = '0;
    res.flags    = flags_in;
    case (op)
      OP_ADD: begin
        res.value = op_a + op_b;
        res.wr    = 1'b1;
      end
      OP_SUB: begin
        res.value = op_a - op_b;
        res.wr    = 1'b1;
      end
      OP_MUL: begin
        res.value = mul_lo;
        res.wr    = 1'b1;
      end
      OP_DIV: begin
        if (op_b == '0) begin
          res.div_zero = 1'b1;
        end else begin
          res.is_div = 1'b1;
          res.wr     = 1'b1;
        end
      end
      OP_AND: begin
        res.value = op_a & op_b;
        res.wr    = 1'b1;
      end
      OP_OR: begin
        res.value = op_a | op_b;
        res.wr    = 1'b1;
      end
      OP_XOR: begin
        res.value = op_a ^ op_b;
        res.wr    = 1'b1;
      end
      OP_SHR: begin
        res.value = $unsigned($signed(op_a) >>> shamt);
        res.wr    = 1'b1;
      end
      OP_SHL: begin
        res.value = op_a << shamt;
        res.wr    = 1'b1;
      end
      OP_MOV: begin
        res.value = op_b;
        res.wr    = 1'b1;
      end
      OP_CMP: begin
        res.flags.zero  = (op_a == '0);
        res.flags.equal = (op_a == op_b);
        res.flags.low   = ($signed(op_a) < $signed(op_b));
        res.flags.great = ($signed(op_a) > $signed(op_b));
      end
      OP_INC: begin
        res.value = op_a + 1'b1;
        res.wr    = 1'b1;
      end
      OP_DEC: begin
        res.value = op_a - 1'b1;
        res.wr    = 1'b1;
      end
      OP_READ: res.value = op_a;
      OP_JMP:  res.jump  = 1'b1;
      OP_JZ:   res.jump  = flags_in.zero;
      OP_JL:   res.jump  = flags_in.low;
      OP_JLE:  res.jump  = flags_in.low | flags_in.equal;
      OP_JE:   res.jump  = flags_in.equal;
      OP_JG:   res.jump  = flags_in.great;
      OP_JGE:  res.jump  = flags_in.great | flags_in.equal;
      default: res.value = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/register_alu_branch_execute_top.sv
// ----------------------------------------------------------------------------
// Register ALU branch execute block
// Executes one register machine instruction per input word against a
// register file memory, a program counter and four compare flags.
// ----------------------------------------------------------------------------
// Channel  Handshake               Word
// in       in_valid / in_ready     rabe_pkg::in_t, one instruction
// out      out_valid / out_ready   rabe_pkg::out_t, one result per instruction
//
// An instruction passes from acceptance to the next acceptance through read
// of the register file memory, execute, write back. A division with a nonzero
// divisor runs the one-bit-per-cycle divider in a divide state before write back.
// Reset clears the control state, the counter, the flags and the register
// valid bits at once. A result word waiting on out_ready holds write back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "register_alu_branch_execute_top_assert.svh"

module register_alu_branch_execute_top #(
  parameter int NUM_REGS      = 10,
  parameter int PROGRAM_LINES = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rabe_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rabe_pkg::out_t      out_data
);
  import rabe_pkg::*;

  localparam int RA_W  = (NUM_REGS > 2) ? $clog2(NUM_REGS) : 1;
  localparam int IX_W  = (RA_W > REG_IDX_W) ? RA_W : REG_IDX_W;
  localparam int PC_W  = $clog2(PROGRAM_LINES);
  localparam int RECIP = (1 << RECIP_SH) / PROGRAM_LINES;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0]        state_r;
  logic [1:0]        state_nxt;
  in_t               in_r;
  logic [PC_W-1:0]   pc_r;
  logic [PC_W-1:0]   pc_nxt;
  logic [PC_W-1:0]   pc_inc;
  flags_t            flags_r;
  flags_t            flg_r;
  logic [DATA_W-1:0] val_r;
  logic              wr_r;
  logic              jump_r;
  logic              err_r;
  logic [PC_W-1:0]   tgt_r;
  logic [TQ_W-1:0]   tq_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic              in_acc;
  logic              wb_commit;
  logic [IX_W-1:0]   ix_a;
  logic [IX_W-1:0]   ix_b;
  logic [IX_W-1:0]   ix_w;
  logic              dst_ok;
  logic              src_ok;
  logic [DATA_W-1:0] rf_a;
  logic [DATA_W-1:0] rf_b;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_b;
  alu_res_t          alu_res;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic              rf_wr_en;
  logic [TPROD_W-1:0] tprod;
  logic [TREM_W-1:0] trem;
  logic [TREM_W-1:0] trem_fix;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign wb_commit = (state_r == S_WB) && (!out_valid_r || out_ready);

  assign ix_a = IX_W'(in_data.dest_reg);
  assign ix_b = IX_W'(in_data.src_reg);
  assign ix_w = IX_W'(in_r.dest_reg);

  assign dst_ok = (32'(in_r.dest_reg) < NUM_REGS);
  assign src_ok = (32'(in_r.src_reg) < NUM_REGS);

  assign rf_wr_en = wb_commit && wr_r && dst_ok;

  rabe_regfile #(
    .NUM_REGS (NUM_REGS),
    .AW       (RA_W)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr_a (ix_a[RA_W-1:0]),
    .rd_addr_b (ix_b[RA_W-1:0]),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b),
    .wr_en     (rf_wr_en),
    .wr_addr   (ix_w[RA_W-1:0]),
    .wr_data   (val_r)
  );

  assign op_a = dst_ok ? rf_a : '0;
  assign op_b = in_r.src_is_imm ? in_r.imm : (src_ok ? rf_b : '0);

  rabe_alu u_alu (
    .op       (in_r.op),
    .op_a     (op_a),
    .op_b     (op_b),
    .flags_in (flags_r),
    .res      (alu_res)
  );

  assign div_start = (state_r == S_EXEC) && alu_res.is_div;

  rabe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (op_a),
    .divisor  (op_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // The jump target is reduced modulo the program length by a reciprocal
  // estimate taken at acceptance and one correcting subtract at execute.
  assign tprod    = TPROD_W'(in_data.target) * TPROD_W'(RECIP);
  assign trem     = TREM_W'(in_r.target) - TREM_W'(tq_r) * TREM_W'(PROGRAM_LINES);
  assign trem_fix = (trem >= TREM_W'(PROGRAM_LINES)) ? (trem - TREM_W'(PROGRAM_LINES)) : trem;

  assign pc_inc = (pc_r == PC_W'(PROGRAM_LINES - 1)) ? '0 : (pc_r + 1'b1);
  assign pc_nxt = err_r ? pc_r : (jump_r ? tgt_r : pc_inc);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = alu_res.is_div ? S_DIV : S_WB;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (wb_commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wb_commit) begin
        pc_r        <= pc_nxt;
        flags_r     <= flg_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
      tq_r <= tprod[RECIP_SH+TQ_W-1:RECIP_SH];
    end
    if (state_r == S_EXEC) begin
      val_r  <= alu_res.value;
      wr_r   <= alu_res.wr;
      jump_r <= alu_res.jump;
      err_r  <= alu_res.div_zero;
      flg_r  <= alu_res.flags;
      tgt_r  <= PC_W'(trem_fix);
    end
    if ((state_r == S_DIV) && div_done) begin
      val_r <= div_q;
    end
    if (wb_commit) begin
      out_data_r.next_pc     <= NPC_W'(pc_nxt);
      out_data_r.value       <= val_r;
      out_data_r.error       <= err_r;
      out_data_r.flag_zero   <= flg_r.zero;
      out_data_r.flag_equal  <= flg_r.equal;
      out_data_r.flag_low    <= flg_r.low;
      out_data_r.flag_great  <= flg_r.great;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RABE_ASSERT_NXT(a_commit_presents, clk, rst_n, wb_commit, out_valid_r, "committed result not presented")
  `RABE_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_done, state_r == S_DIV, "divider finished outside divide state")
  `RABE_ASSERT_NXT(a_error_holds_pc, clk, rst_n, wb_commit && err_r, pc_r == $past(pc_r), "division by zero moved the counter")

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Register ALU branch execute testbench
// Drives instruction words into the execute block with random gaps and output
// stalls, predicts each result word from an internal model of the register
// file, counter and compare flags, and checks every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import rabe_pkg::*;

  localparam int NUM_REGS      = 10;
  localparam int PROGRAM_LINES = 1024;
  localparam int MAX_REG_IDX   = 2**REG_IDX_W - 1;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 5'd21;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED  = 5'd31;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  logic [DATA_W-1:0] mach_regs [NUM_REGS];
  logic [NPC_W-1:0]  mach_pc;
  flags_t            mach_flags;
  out_t              pending_results [$];

  int unsigned send_gap_max      = 7;
  int unsigned recv_stall_max    = 7;
  int unsigned stall_left        = 0;
  int unsigned hold_left         = 0;
  logic        out_hold_request  = 1'b0;
  int unsigned mismatch_count    = 0;
  int unsigned cycle_count       = 0;

  register_alu_branch_execute_top #(
    .NUM_REGS      (NUM_REGS),
    .PROGRAM_LINES (PROGRAM_LINES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] read_reg(input logic [REG_IDX_W-1:0] idx);
    if (idx < NUM_REGS) begin
      return mach_regs[idx];
    end
    return '0;
  endfunction

  function automatic out_t execute_instr(input in_t w);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] ma;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] res;
    logic [NPC_W-1:0]  npc;
    logic              wr;
    logic              jump;
    logic              err;
    out_t              o;
    a    = read_reg(w.dest_reg);
    b    = w.src_is_imm ? w.imm : read_reg(w.src_reg);
    npc  = mach_pc + 1'b1;
    res  = '0;
    wr   = 1'b0;
    jump = 1'b0;
    err  = 1'b0;
    case (w.op)
      OP_ADD: begin res = a + b; wr = 1'b1; end
      OP_SUB: begin res = a - b; wr = 1'b1; end
      OP_MUL: begin res = a * b; wr = 1'b1; end
      OP_DIV: begin
        if (b == '0) begin
          err = 1'b1;
          npc = mach_pc;
        end else begin
          ma  = a[DATA_W-1] ? -a : a;
          mb  = b[DATA_W-1] ? -b : b;
          q   = ma / mb;
          res = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
          wr  = 1'b1;
        end
      end
      OP_AND: begin res = a & b; wr = 1'b1; end
      OP_OR:  begin res = a | b; wr = 1'b1; end
      OP_XOR: begin res = a ^ b; wr = 1'b1; end
      OP_SHR: begin res = $signed(a) >>> b[4:0]; wr = 1'b1; end
      OP_SHL: begin res = a << b[4:0]; wr = 1'b1; end
      OP_MOV: begin res = b; wr = 1'b1; end
      OP_CMP: begin
        mach_flags.zero  = (a == '0);
        mach_flags.equal = (a == b);
        mach_flags.low   = ($signed(a) < $signed(b));
        mach_flags.great = ($signed(a) > $signed(b));
      end
      OP_INC:  begin res = a + 1'b1; wr = 1'b1; end
      OP_DEC:  begin res = a - 1'b1; wr = 1'b1; end
      OP_READ: res = a;
      OP_JMP:  jump = 1'b1;
      OP_JZ:   jump = mach_flags.zero;
      OP_JL:   jump = mach_flags.low;
      OP_JLE:  jump = mach_flags.low | mach_flags.equal;
      OP_JE:   jump = mach_flags.equal;
      OP_JG:   jump = mach_flags.great;
      OP_JGE:  jump = mach_flags.great | mach_flags.equal;
      default: ;
    endcase
    if (wr && w.dest_reg < NUM_REGS) begin
      mach_regs[w.dest_reg] = res;
    end
    if (jump) begin
      npc = w.target;
    end
    mach_pc      = npc;
    o.next_pc    = npc;
    o.value      = res;
    o.error      = err;
    o.flag_zero  = mach_flags.zero;
    o.flag_equal = mach_flags.equal;
    o.flag_low   = mach_flags.low;
    o.flag_great = mach_flags.great;
    return o;
  endfunction

  function automatic in_t make_instr(input logic [OP_W-1:0] op,
                                     input logic [REG_IDX_W-1:0] dest,
                                     input logic is_imm,
                                     input logic [REG_IDX_W-1:0] src,
                                     input logic [DATA_W-1:0] imm,
                                     input logic [TGT_W-1:0] target);
    in_t w;
    w.op         = op;
    w.dest_reg   = dest;
    w.src_is_imm = is_imm;
    w.src_reg    = src;
    w.imm        = imm;
    w.target     = target;
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 40);
      5:       return -$urandom_range(1, 40);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [REG_IDX_W-1:0] random_reg_idx();
    if ($urandom_range(0, 11) == 0) begin
      return REG_IDX_W'($urandom_range(NUM_REGS, MAX_REG_IDX));
    end
    return REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
  endfunction

  function automatic in_t random_instr();
    logic [OP_W-1:0] op;
    if ($urandom_range(0, 19) == 0) begin
      op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    end else begin
      op = OP_W'($urandom_range(OP_ADD, OP_JGE));
    end
    return make_instr(op, random_reg_idx(), 1'($urandom_range(0, 1)), random_reg_idx(),
                      random_operand(), TGT_W'($urandom_range(0, PROGRAM_LINES - 1)));
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Entered at a falling edge; leaves the accepted word on the bus and returns
  // at the next falling edge so that a following word can replace it at once.
  task automatic send_word(input in_t w);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(execute_instr(w));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_corners();
    send_word(make_instr(OP_MOV, 0, 1'b1, 0, 32'h7fff_ffff, 0));
    send_word(make_instr(OP_MOV, 1, 1'b1, 0, 32'h8000_0000, 0));
    send_word(make_instr(OP_ADD, 0, 1'b1, 0, 32'd1, 0));
    send_word(make_instr(OP_SUB, 1, 1'b1, 0, 32'd1, 0));
    send_word(make_instr(OP_MOV, 2, 1'b1, 0, -32'sd7, 0));
    send_word(make_instr(OP_MOV, 3, 1'b1, 0, 32'd2, 0));
    send_word(make_instr(OP_DIV, 2, 1'b0, 3, '0, 0));
    send_word(make_instr(OP_MUL, 2, 1'b1, 0, 32'h7fff_ffff, 0));
    send_word(make_instr(OP_DIV, 4, 1'b0, 5, '0, 0));
    send_word(make_instr(OP_DIV, 3, 1'b1, 0, '0, 0));
    send_word(make_instr(OP_MOV, 6, 1'b1, 0, 32'h8000_0000, 0));
    send_word(make_instr(OP_DIV, 6, 1'b1, 0, '1, 0));
    send_word(make_instr(OP_AND, 0, 1'b1, 0, 32'hf0f0_f0f0, 0));
    send_word(make_instr(OP_OR, 4, 1'b0, 0, '0, 0));
    send_word(make_instr(OP_XOR, 4, 1'b1, 0, '1, 0));
    send_word(make_instr(OP_SHR, 1, 1'b1, 0, 32'd63, 0));
    send_word(make_instr(OP_SHL, 3, 1'b1, 0, 32'd33, 0));
    send_word(make_instr(OP_CMP, 3, 1'b1, 0, 32'd4, 0));
    send_word(make_instr(OP_JLE, 0, 1'b0, 0, '0, 10'd1023));
    send_word(make_instr(OP_JL, 0, 1'b0, 0, '0, 10'd5));
    send_word(make_instr(OP_CMP, 7, 1'b0, 1, '0, 0));
    send_word(make_instr(OP_JG, 0, 1'b0, 0, '0, 10'd17));
    send_word(make_instr(OP_JZ, 0, 1'b0, 0, '0, 10'd0));
    send_word(make_instr(OP_INC, 9, 1'b1, 0, '1, 0));
    send_word(make_instr(OP_DEC, 8, 1'b0, 2, '0, 0));
    send_word(make_instr(OP_MOV, 15, 1'b1, 0, 32'd5, 0));
    send_word(make_instr(OP_READ, 12, 1'b0, 0, '0, 0));
    send_word(make_instr(OP_ADD, 9, 1'b0, 14, '0, 0));
    send_word(make_instr(OP_LAST_UNUSED, 2, 1'b1, 0, '1, 10'd1023));
    send_word(make_instr(OP_JMP, 0, 1'b0, 0, '0, 10'd1023));
    send_word(make_instr(OP_READ, 9, 1'b0, 0, '0, 0));
  endtask

  task automatic test_random_alu(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      send_word(random_instr());
    end
  endtask

  // Compare followed by a jump, with operands often equal or adjacent so that
  // every flag combination steers the counter.
  task automatic test_branch_sequences(input int unsigned count);
    logic [REG_IDX_W-1:0] r;
    logic [DATA_W-1:0]    rhs;
    for (int i = 0; i < count; i++) begin
      r = REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
      if ($urandom_range(0, 3) == 0) begin
        send_word(make_instr(OP_MOV, r, 1'b1, 0, random_operand(), 0));
      end
      case ($urandom_range(0, 3))
        0:       rhs = mach_regs[r];
        1:       rhs = mach_regs[r] + 1'b1;
        2:       rhs = mach_regs[r] - 1'b1;
        default: rhs = random_operand();
      endcase
      if ($urandom_range(0, 4) == 0) begin
        send_word(make_instr(OP_CMP, r, 1'b0, random_reg_idx(), rhs, 0));
      end else begin
        send_word(make_instr(OP_CMP, r, 1'b1, random_reg_idx(), rhs, 0));
      end
      send_word(make_instr(OP_W'($urandom_range(OP_JMP, OP_JGE)), random_reg_idx(),
                           1'($urandom_range(0, 1)), random_reg_idx(), $urandom(),
                           TGT_W'($urandom_range(0, PROGRAM_LINES - 1))));
      if ($urandom_range(0, 2) == 0) begin
        send_word(random_instr());
      end
    end
  endtask

  task automatic test_output_hold(input int unsigned count);
    in_valid <= 1'b0;
    @(posedge clk);
    out_hold_request = 1'b1;
    @(negedge clk);
    send_gap_max = 0;
    test_random_alu(count);
    send_gap_max = 7;
  endtask

  task automatic test_back_to_back(input int unsigned count);
    send_gap_max   = 0;
    recv_stall_max = 0;
    test_random_alu(count);
    send_gap_max   = 7;
    recv_stall_max = 7;
  endtask

  always @(negedge clk) begin
    if (out_hold_request) begin
      hold_left        = LONG_HOLD;
      out_hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      stall_left = $urandom_range(0, recv_stall_max);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, value", out_data.value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.next_pc !== want.next_pc)
          report_mismatch("next_pc", DATA_W'(out_data.next_pc),
                          DATA_W'(want.next_pc));
        if (out_data.value !== want.value)
          report_mismatch("value", out_data.value, want.value);
        if (out_data.error !== want.error)
          report_mismatch("error", DATA_W'(out_data.error), DATA_W'(want.error));
        if (out_data.flag_zero !== want.flag_zero)
          report_mismatch("flag_zero", DATA_W'(out_data.flag_zero),
                          DATA_W'(want.flag_zero));
        if (out_data.flag_equal !== want.flag_equal)
          report_mismatch("flag_equal", DATA_W'(out_data.flag_equal),
                          DATA_W'(want.flag_equal));
        if (out_data.flag_low !== want.flag_low)
          report_mismatch("flag_low", DATA_W'(out_data.flag_low),
                          DATA_W'(want.flag_low));
        if (out_data.flag_great !== want.flag_great)
          report_mismatch("flag_great", DATA_W'(out_data.flag_great),
                          DATA_W'(want.flag_great));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d result words outstanding", $realtime,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (mach_regs[i]) begin
      mach_regs[i] = '0;
    end
    mach_pc    = '0;
    mach_flags = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    wait_results_drained();
    test_random_alu(600);
    test_branch_sequences(140);
    wait_results_drained();
    test_output_hold(60);
    test_back_to_back(200);
    test_random_alu(60);
    wait_results_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
